// ===== src/rsht_pkg.sv =====
// Shared constants for the replay signal history table.
package rsht_pkg;

  localparam int HISTORY_DEPTH_DEF = 32;

  localparam int HASH_W   = 32;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0]  WINDOW_RST    = TIME_W'(60000);
  localparam logic [COUNT_W-1:0] THRESHOLD_RST = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

endpackage

// ===== src/replay_signal_history_table_core.sv =====
// Replay signal history table: ring of recent signal hashes with replay flagging.
//
// Each input transfer carries a signal hash and the current millisecond tick.
// The block scans the valid history entries in index order through one
// registered read port and one hash comparator, one entry per cycle. The first
// matching entry wins: if it was seen less than the window (register 0) ticks
// ago its count rises (saturating at 255), its time is refreshed and is_replay
// is set when the count reaches replay_threshold; a stale match changes
// nothing. With no match the entry at the ring head is written with count 1
// and the head advances. One result transfer follows every input transfer. An
// item is accepted, then scanned until the first match or the last entry, then
// its update and result are made once the result register is free. The input
// is ready only while the sequencer is idle. Configuration writes are always
// taken; write them only while idle.
module replay_signal_history_table_core #(
  parameter int HISTORY_DEPTH = rsht_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [31:0] signal_hash, [63:32] now_ms
  input  logic [rsht_pkg::IN_DATA_W-1:0]      s_tdata,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] is_replay, [1] newly_added, [9:2] times_seen, [15:10] zero
  output logic [rsht_pkg::OUT_DATA_W-1:0]     m_tdata,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rsht_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsht_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(HISTORY_DEPTH);

  localparam int HW = rsht_pkg::HASH_W;
  localparam int TW = rsht_pkg::TIME_W;
  localparam int NW = rsht_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;

  // configuration registers
  logic [TW-1:0] window_ticks;
  logic [NW-1:0] replay_threshold;

  // history storage: valid bits in flops, payload in memory
  logic [HISTORY_DEPTH-1:0] entry_valid;
  logic [HW-1:0] entry_hash  [HISTORY_DEPTH];
  logic [TW-1:0] entry_time  [HISTORY_DEPTH];
  logic [NW-1:0] entry_count [HISTORY_DEPTH];
  logic [IW-1:0] ring_head;

  // latched item
  logic [HW-1:0] key_hash;
  logic [TW-1:0] key_now;

  // scan pipeline
  logic [CW-1:0] issue;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic [HW-1:0] rd_hash;
  logic [TW-1:0] rd_time;
  logic [NW-1:0] rd_count;
  logic          found;

  // result register
  logic          res_replay;
  logic          res_new;
  logic [NW-1:0] res_count;

  logic          in_xfer;
  logic          out_free;
  logic          hit;
  logic          last;
  logic          rd_en;
  logic [TW-1:0] age;
  logic          recent;
  logic [NW-1:0] count_upd;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [TW-1:0] wr_time;
  logic [NW-1:0] wr_count;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign m_tdata = {{(rsht_pkg::OUT_DATA_W - NW - 2){1'b0}}, res_count, res_new, res_replay};

  // the one comparator of the scan: previous read against the key
  assign hit   = (state == S_SCAN) && rd_vld && entry_valid[rd_idx] && (rd_hash == key_hash);
  assign last  = rd_vld && (rd_idx == LAST_IDX);
  assign rd_en = (state == S_SCAN) && !hit && (issue < DEPTH_CNT);

  // age check on the matched entry
  always_comb begin
    age       = key_now - rd_time;
    recent    = age < window_ticks;
    count_upd = (rd_count == rsht_pkg::COUNT_MAX) ? rd_count : rd_count + NW'(1);
    wr_en     = (state == S_FIN) && out_free && (!found || recent);
    wr_addr   = found ? rd_idx : ring_head;
    wr_time   = key_now;
    wr_count  = found ? count_upd : NW'(1);
  end

  // history memory: one registered read, one write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hash  <= entry_hash[issue[IW-1:0]];
      rd_time  <= entry_time[issue[IW-1:0]];
      rd_count <= entry_count[issue[IW-1:0]];
      rd_idx   <= issue[IW-1:0];
    end
    if (wr_en) begin
      entry_hash[wr_addr]  <= key_hash;
      entry_time[wr_addr]  <= wr_time;
      entry_count[wr_addr] <= wr_count;
    end
  end

  // latch the item on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_hash <= s_tdata[HW-1:0];
      key_now  <= s_tdata[HW+TW-1:HW];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks     <= rsht_pkg::WINDOW_RST;
      replay_threshold <= rsht_pkg::THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsht_pkg::REG_WINDOW:    window_ticks     <= cfg_data[TW-1:0];
        rsht_pkg::REG_THRESHOLD: replay_threshold <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      ring_head   <= '0;
      issue       <= '0;
      rd_vld      <= 1'b0;
      found       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // drop tvalid after its transfer unless a new result loads this cycle
      if (m_tvalid && m_tready && !((state == S_FIN) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            issue  <= '0;
            rd_vld <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // advance the read pointer unless the scan stops here
          if (rd_en) begin
            issue <= issue + CW'(1);
          end
          rd_vld <= rd_en;
          if (hit) begin
            found <= 1'b1;
            state <= S_FIN;
          end else if (last) begin
            found <= 1'b0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the result register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (found) begin
              res_new    <= 1'b0;
              res_replay <= recent && (count_upd >= replay_threshold);
              res_count  <= recent ? count_upd : rd_count;
            end else begin
              res_new                <= 1'b1;
              res_replay             <= 1'b0;
              res_count              <= NW'(1);
              entry_valid[ring_head] <= 1'b1;
              ring_head <= (ring_head == LAST_IDX) ? '0 : ring_head + IW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/replay_signal_history_table_core_test.sv =====
// Self-checking testbench for the replay signal history table core.
`timescale 1ns / 100ps

module replay_signal_history_table_core_test;

  localparam int DEPTH        = rsht_pkg::HISTORY_DEPTH_DEF;
  // Leave a margin after the last result before touching registers.
  localparam int SETTLE       = DEPTH + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int POOL_SIZE    = 48;
  localparam int DRAIN_GUARD  = 50000;
  localparam longint TIMEOUT_NS = 64'd8_000_000;

  // Expected content of one result transfer.
  typedef struct packed {
    logic                         is_replay;
    logic                         newly_added;
    logic [rsht_pkg::COUNT_W-1:0] times_seen;
  } verdict_t;

  // Shadow copy of the history ring plus the queue of verdicts still owed.
  class replay_verdict_board;
    bit                           slot_live [DEPTH];
    logic [rsht_pkg::HASH_W-1:0]  slot_hash [DEPTH];
    logic [rsht_pkg::TIME_W-1:0]  slot_tick [DEPTH];
    logic [rsht_pkg::COUNT_W-1:0] slot_count[DEPTH];
    int unsigned                  head;
    logic [rsht_pkg::TIME_W-1:0]  window;
    logic [rsht_pkg::COUNT_W-1:0] threshold;
    verdict_t                     expected_verdicts[$];
    int unsigned                  mismatches;
    int unsigned                  results_seen;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_live[i]  = 1'b0;
        slot_hash[i]  = '0;
        slot_tick[i]  = '0;
        slot_count[i] = '0;
      end
      head         = 0;
      window       = rsht_pkg::WINDOW_RST;
      threshold    = rsht_pkg::THRESHOLD_RST;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [rsht_pkg::CFG_IDX_W-1:0] idx,
                            logic [rsht_pkg::CFG_DATA_W-1:0] data);
      if (idx == rsht_pkg::REG_WINDOW)
        window = data[rsht_pkg::TIME_W-1:0];
      else if (idx == rsht_pkg::REG_THRESHOLD)
        threshold = data[rsht_pkg::COUNT_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    // Look up the first live slot with this hash, update the ring and queue the verdict.
    function void note_sighting(logic [rsht_pkg::HASH_W-1:0] hash,
                                logic [rsht_pkg::TIME_W-1:0] now);
      verdict_t                    v;
      logic [rsht_pkg::TIME_W-1:0] age;
      int                          hit;
      hit = -1;
      v   = '0;
      for (int i = 0; i < DEPTH; i++)
        if (hit < 0 && slot_live[i] && slot_hash[i] == hash) hit = i;
      if (hit >= 0) begin
        age = now - slot_tick[hit];
        if (age < window) begin
          if (slot_count[hit] != rsht_pkg::COUNT_MAX) slot_count[hit] = slot_count[hit] + 1'b1;
          slot_tick[hit] = now;
          v.is_replay    = (slot_count[hit] >= threshold);
        end
        v.times_seen = slot_count[hit];
      end else begin
        slot_live[head]  = 1'b1;
        slot_hash[head]  = hash;
        slot_tick[head]  = now;
        slot_count[head] = rsht_pkg::COUNT_W'(1);
        head             = (head + 1 >= DEPTH) ? 0 : head + 1;
        v.newly_added    = 1'b1;
        v.times_seen     = rsht_pkg::COUNT_W'(1);
      end
      expected_verdicts.push_back(v);
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_verdict(logic [rsht_pkg::OUT_DATA_W-1:0] word);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("result 0x%04h with nothing outstanding", word));
        return;
      end
      want = expected_verdicts.pop_front();
      results_seen++;
      if (word[0] !== want.is_replay)
        report($sformatf("result %0d is_replay %b, want %b",
                         results_seen, word[0], want.is_replay));
      if (word[1] !== want.newly_added)
        report($sformatf("result %0d newly_added %b, want %b",
                         results_seen, word[1], want.newly_added));
      if (word[9:2] !== want.times_seen)
        report($sformatf("result %0d times_seen %0d, want %0d",
                         results_seen, word[9:2], want.times_seen));
      if (word[15:10] !== '0)
        report($sformatf("result %0d padding bits 0x%02h not zero",
                         results_seen, word[15:10]));
    endtask

    task close_out();
      if (expected_verdicts.size() != 0)
        report($sformatf("%0d results never arrived", expected_verdicts.size()));
    endtask
  endclass

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [rsht_pkg::IN_DATA_W-1:0]    s_tdata;   // [31:0] signal_hash, [63:32] now_ms
  logic                              m_tvalid;
  logic                              m_tready;
  logic [rsht_pkg::OUT_DATA_W-1:0]   m_tdata;   // [0] is_replay, [1] newly_added, [9:2] times_seen
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [rsht_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [rsht_pkg::CFG_DATA_W-1:0]   cfg_data;

  replay_verdict_board board = new();

  // Stimulus-side state: current tick, active window and the hash pool that
  // makes repeats common enough to build up counts.
  logic [rsht_pkg::TIME_W-1:0] now_tick;
  logic [rsht_pkg::TIME_W-1:0] cur_window;
  logic [rsht_pkg::HASH_W-1:0] hash_pool[POOL_SIZE];
  bit                          no_idle;   // set for the stretch without gaps on either side
  bit                          hold_req;  // ask the result side for a long hold-off

  replay_signal_history_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic bit idle_roll();
    return !no_idle && ($urandom_range(0, 99) < 35);
  endfunction

  // Result side: randomize tready at each falling edge, honor hold-off requests.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // Hold tready low through the hold-off so the block fills and stalls its input.
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= !idle_roll();
    end
  end

  // Check every result transfer against the oldest outstanding verdict.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_verdict(m_tdata);
  end

  // Offer one item; called and returning at a falling edge. Random gaps go
  // in front of the item, so tvalid stays high between back-to-back items.
  task automatic send_item(logic [rsht_pkg::HASH_W-1:0] hash,
                           logic [rsht_pkg::TIME_W-1:0] now);
    while (idle_roll()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, hash};
    do @(posedge clk); while (!s_tready);
    // The transfer happened at this edge; record what it should produce.
    board.note_sighting(hash, now);
    @(negedge clk);
  endtask

  // Write one register, then drop valid on a fresh edge so back-to-back
  // writes never raise and lower valid in the same step.
  task automatic write_reg(logic [rsht_pkg::CFG_IDX_W-1:0] idx,
                           logic [rsht_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop the input, wait for every owed result, then let the block go idle.
  task automatic wait_quiet();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (board.pending() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly repeats from the pool with small tick steps scaled to the window,
  // so recent and stale matches both show up; the rest is fresh hashes and
  // random tick jumps (which also exercise wraparound of the age).
  task automatic random_items(int count, int hold_at);
    logic [rsht_pkg::HASH_W-1:0] hash;
    logic [rsht_pkg::TIME_W-1:0] step_max;
    step_max = cur_window / 32;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85)
        hash = hash_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        hash = $urandom;
      if ($urandom_range(0, 99) < 8)
        now_tick = $urandom;
      else
        now_tick = now_tick + $urandom_range(0, step_max);
      if (k == hold_at) hold_req = 1'b1;
      send_item(hash, now_tick);
    end
  endtask

  // Reconfigure while idle, refresh the hash pool and run random traffic.
  task automatic run_phase(logic [rsht_pkg::TIME_W-1:0] window,
                           logic [rsht_pkg::COUNT_W-1:0] thr,
                           int count, int hold_at);
    wait_quiet();
    write_reg(rsht_pkg::REG_WINDOW, window);
    // Upper data bits are junk on purpose; only the low byte is the threshold.
    write_reg(rsht_pkg::REG_THRESHOLD, {24'($urandom), thr});
    cur_window = window;
    for (int i = 0; i < POOL_SIZE; i++) hash_pool[i] = $urandom;
    random_items(count, hold_at);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    now_tick  = '0;
    cur_window = rsht_pkg::WINDOW_RST;
    for (int i = 0; i < POOL_SIZE; i++) hash_pool[i] = $urandom;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items under the reset settings (window 60000, threshold 3).
    send_item(32'h0000_0000, 32'h0000_0000);  // first entry
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // all-ones hash and tick
    send_item(32'h0000_0000, 32'd10);         // recent repeat, count 2
    send_item(32'h0000_0000, 32'd20);         // count reaches threshold: replay
    send_item(32'hFFFF_FFFF, 32'd100);        // age wraps past 2^32, still recent
    send_item(32'h0000_0000, 32'd60020);      // age equals window: stale, no change
    send_item(32'h0000_0000, 32'd60019);      // one tick inside the window
    send_item(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_item(32'hA5A5_A5A5, 32'h5A5A_5A5A);  // zero age
    send_item(32'h5A5A_5A5A, 32'hA5A5_A5A5);

    // Window zero: every match is stale.
    run_phase(32'd0, 8'd3, 120, -1);
    // Smallest nonzero window, threshold one: only same-tick repeats count.
    run_phase(32'd1, 8'd1, 150, -1);

    // Widest window, highest threshold: drive one hash past count
    // saturation, with no gaps on either side for the whole stretch.
    run_phase(32'hFFFF_FFFF, 8'd255, 0, -1);
    no_idle = 1'b1;
    for (int k = 0; k < 270; k++) begin
      now_tick = now_tick + 1;
      send_item(32'h0F0F_0F0F, now_tick);
    end
    random_items(100, -1);
    no_idle = 1'b0;

    // Threshold zero: every recent match is a replay.
    run_phase(32'd1000, 8'd0, 200, -1);
    // Long result-side hold-off while items keep coming.
    run_phase(32'd5000, 8'd5, 400, 40);
    run_phase(32'd60000, 8'd2, 200, -1);
    run_phase(32'h8000_0000, 8'd128, 150, -1);

    wait_quiet();
    board.close_out();
    if (board.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/rsht_pkg.sv
src/replay_signal_history_table_core.sv
bench/replay_signal_history_table_core_test.sv
